>>> rtl/assert_macros.svh
// Assertion macros used by the RTL of the 14-bit controller and NRPN decoder.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Check that a condition leads to a consequence on the next clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/mcnd_pkg.sv
// Package for the 14-bit controller and NRPN decoder: sizes, controller codes,
// slot and record types. No dependencies.
package mcnd_pkg;

   localparam int PAIR_SLOTS  = 4;
   localparam int CHANNELS    = 16;
   localparam int CONFIG_REGS = 4;

   localparam int CHAN_W    = 4;
   localparam int BYTE_W    = 7;
   localparam int CTL_W     = 5;
   localparam int SLOT_W    = 10;
   localparam int WORD_W    = 14;
   localparam int CSR_IDX_W = (CONFIG_REGS > 1) ? $clog2(CONFIG_REGS) : 1;
   localparam int CHAN_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic [BYTE_W-1:0] LSB_OFFSET   = 7'd32;
   localparam logic [BYTE_W-1:0] CC_PARAM_MSB = 7'd99;
   localparam logic [BYTE_W-1:0] CC_PARAM_LSB = 7'd98;
   localparam logic [BYTE_W-1:0] CC_DATA_MSB  = 7'd6;
   localparam logic [BYTE_W-1:0] CC_DATA_LSB  = 7'd38;

   typedef struct packed {
      logic              enable;
      logic [CHAN_W-1:0] chan;
      logic [CTL_W-1:0]  ctl;
   } pair_slot_type;

   typedef struct packed {
      logic [BYTE_W-1:0] param_msb;
      logic [BYTE_W-1:0] param_lsb;
      logic [BYTE_W-1:0] data_msb;
      logic [BYTE_W-1:0] data_lsb;
   } nrpn_rec_type;

   localparam int REC_W = $bits(nrpn_rec_type);

endpackage

>>> rtl/mcnd_if.sv
// Channel interfaces of the decoder: request, response and register write.
// Depends on mcnd_pkg.
interface mcnd_req_if;
   logic                         valid;
   logic                         ready;
   logic                         is_control_change;
   logic [mcnd_pkg::CHAN_W-1:0]  chan;
   logic [mcnd_pkg::BYTE_W-1:0]  byte_one;
   logic [mcnd_pkg::BYTE_W-1:0]  byte_two;

   modport source (output valid, is_control_change, chan, byte_one, byte_two,
                   input ready);
   modport sink   (input valid, is_control_change, chan, byte_one, byte_two,
                   output ready);
endinterface

interface mcnd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mcnd_pkg::CHAN_W-1:0]  out_chan;
   logic [mcnd_pkg::BYTE_W-1:0]  out_byte_one;
   logic [mcnd_pkg::BYTE_W-1:0]  out_byte_two;
   logic                         pair_valid;
   logic [mcnd_pkg::BYTE_W-1:0]  pair_lsb;
   logic                         nrpn_valid;
   logic [mcnd_pkg::WORD_W-1:0]  nrpn_param;
   logic [mcnd_pkg::WORD_W-1:0]  nrpn_value;

   modport source (output valid, out_chan, out_byte_one, out_byte_two, pair_valid,
                   pair_lsb, nrpn_valid, nrpn_param, nrpn_value, input ready);
   modport sink   (input valid, out_chan, out_byte_one, out_byte_two, pair_valid,
                   pair_lsb, nrpn_valid, nrpn_param, nrpn_value, output ready);
endinterface

interface mcnd_csr_if;
   logic                           valid;
   logic                           ready;
   logic [mcnd_pkg::CSR_IDX_W-1:0] index;
   logic [mcnd_pkg::SLOT_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/midi_cc14_nrpn_decoder_unit.sv
// 14-bit controller and NRPN decoder: pairs MSB/LSB controllers per slot, then
// assembles NRPN parameter/value words per channel. Depends on mcnd_pkg,
// mcnd_if, mcnd_ram and assert_macros.svh.
//
// The block takes one request per clock while not stalled and returns one response
// per request, in order, via the stage 1 registers and the output register when the
// response side is ready. On acceptance, stage 0 compares the request against all
// pairing slots in parallel and issues the read of the channel's NRPN record from a
// 16-entry RAM; stage 1 updates that record, writes it back and loads the output register.
// A record written in the cycle a later request reads it is forwarded around
// the RAM, so back-to-back requests on one channel see each other's updates.
// Per-entry valid bits make every record read as zero after reset, so there is
// no clearing pass and requests are taken from the first cycle after reset.
// The user must write the pairing slots through the register port only while the
// block is idle; the block itself does not enforce this. That port is always ready.
// While the response is stalled, the block holds up to two requests, one in the
// stage 1 registers and one in the output register, and stops accepting new ones.
`include "assert_macros.svh"

module midi_cc14_nrpn_decoder_unit (
   input logic        clock,
   input logic        reset,
   mcnd_req_if.sink   req_port,
   mcnd_rsp_if.source rsp_port,
   mcnd_csr_if.sink   csr_port
);

   // ---------------------------------------------------------------------
   // Configuration: pairing slots
   // ---------------------------------------------------------------------
   mcnd_pkg::pair_slot_type slot_ff [mcnd_pkg::PAIR_SLOTS];
   logic csr_fire;

   assign csr_port.ready = 1'b1;
   assign csr_fire       = csr_port.valid;

   // Slots beyond the register list stay zero, hence disabled.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mcnd_pkg::PAIR_SLOTS; i++) begin
            slot_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < mcnd_pkg::PAIR_SLOTS; i++) begin
            if (i < mcnd_pkg::CONFIG_REGS && csr_fire &&
                csr_port.index == mcnd_pkg::CSR_IDX_W'(i)) begin
               slot_ff[i] <= mcnd_pkg::pair_slot_type'(csr_port.data);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Handshake and pipeline control
   // ---------------------------------------------------------------------
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic out_free;
   logic s1_adv;
   logic req_fire;

   // Output register frees when empty or being drained this cycle.
   assign out_free       = !rsp_valid_ff || rsp_port.ready;
   assign s1_adv         = s1_valid_ff && out_free;
   assign req_port.ready = !s1_valid_ff || s1_adv;
   assign req_fire       = req_port.valid && req_port.ready;

   // ---------------------------------------------------------------------
   // Stage 0: 14-bit controller pairing, first matching slot wins
   // ---------------------------------------------------------------------
   logic [mcnd_pkg::BYTE_W-1:0] msb_store_ff [mcnd_pkg::PAIR_SLOTS];
   logic [mcnd_pkg::PAIR_SLOTS-1:0] msb_wr;
   logic                        pair_found;
   logic                        pr_valid;
   logic [mcnd_pkg::BYTE_W-1:0] pr_lsb;
   logic [mcnd_pkg::BYTE_W-1:0] pr_b1;
   logic [mcnd_pkg::BYTE_W-1:0] pr_b2;
   logic [mcnd_pkg::BYTE_W-1:0] slot_msb_ctl [mcnd_pkg::PAIR_SLOTS];

   always_comb begin
      msb_wr     = '0;
      pair_found = 1'b0;
      pr_valid   = 1'b0;
      pr_lsb     = '0;
      pr_b1      = req_port.byte_one;
      pr_b2      = req_port.byte_two;
      for (int i = 0; i < mcnd_pkg::PAIR_SLOTS; i++) begin
         slot_msb_ctl[i] = mcnd_pkg::BYTE_W'(slot_ff[i].ctl);
         if (req_port.is_control_change && !pair_found && slot_ff[i].enable &&
             slot_ff[i].chan == req_port.chan) begin
            if (req_port.byte_one == slot_msb_ctl[i]) begin
               // MSB controller: remember the value, pass the message on
               msb_wr[i]  = 1'b1;
               pair_found = 1'b1;
            end else if (req_port.byte_one == slot_msb_ctl[i] + mcnd_pkg::LSB_OFFSET) begin
               // LSB controller: report it, rewrite as the MSB controller
               pr_valid   = 1'b1;
               pr_lsb     = req_port.byte_two;
               pr_b1      = slot_msb_ctl[i];
               pr_b2      = msb_store_ff[i];
               pair_found = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mcnd_pkg::PAIR_SLOTS; i++) begin
            msb_store_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < mcnd_pkg::PAIR_SLOTS; i++) begin
            if (req_fire && msb_wr[i]) begin
               msb_store_ff[i] <= req_port.byte_two;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // NRPN record store: RAM read issued on accept, write back in stage 1
   // ---------------------------------------------------------------------
   logic                          req_in_store;
   logic [mcnd_pkg::CHAN_AW-1:0]  req_addr;
   logic [mcnd_pkg::CHANNELS-1:0] entry_vld_ff;
   logic [mcnd_pkg::REC_W-1:0]    ram_rd_data;
   logic                          rec_wr;
   mcnd_pkg::nrpn_rec_type        rec_base;
   mcnd_pkg::nrpn_rec_type        rec_new;

   // Channels at or above the store depth touch no record.
   assign req_in_store = {1'b0, req_port.chan} < (mcnd_pkg::CHAN_W + 1)'(mcnd_pkg::CHANNELS);
   assign req_addr     = mcnd_pkg::CHAN_AW'(req_port.chan);

   // Stage 1 registers
   logic                         s1_cc_ff;
   logic                         s1_in_store_ff;
   logic [mcnd_pkg::CHAN_W-1:0]  s1_chan_ff;
   logic [mcnd_pkg::CHAN_AW-1:0] s1_addr_ff;
   logic [mcnd_pkg::BYTE_W-1:0]  s1_b1_ff;
   logic [mcnd_pkg::BYTE_W-1:0]  s1_b2_ff;
   logic                         s1_pvalid_ff;
   logic [mcnd_pkg::BYTE_W-1:0]  s1_plsb_ff;
   logic                         s1_fwd_ff;
   logic                         s1_fwd_in;
   mcnd_pkg::nrpn_rec_type       s1_fwd_rec_ff;
   logic                         s1_present_ff;

   mcnd_ram #(
      .WIDTH (mcnd_pkg::REC_W),
      .DEPTH (mcnd_pkg::CHANNELS)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (s1_adv && rec_wr),
      .wr_addr (s1_addr_ff),
      .wr_data (rec_new),
      .rd_en   (req_fire),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   // Forward the record being written at the edge that issues the read.
   assign s1_fwd_in = s1_adv && rec_wr && s1_addr_ff == req_addr;

   always_comb begin
      if (s1_fwd_ff) begin
         rec_base = s1_fwd_rec_ff;
      end else if (s1_present_ff) begin
         rec_base = mcnd_pkg::nrpn_rec_type'(ram_rd_data);
      end else begin
         rec_base = '0;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: NRPN assembly on the possibly rewritten message
   // ---------------------------------------------------------------------
   logic                        nr_valid;
   logic [mcnd_pkg::WORD_W-1:0] nr_param;
   logic [mcnd_pkg::WORD_W-1:0] nr_value;

   always_comb begin
      rec_new  = rec_base;
      rec_wr   = 1'b0;
      nr_valid = 1'b0;
      nr_param = '0;
      nr_value = '0;
      if (s1_cc_ff && s1_in_store_ff) begin
         unique case (s1_b1_ff)
            mcnd_pkg::CC_PARAM_MSB: begin
               // clear the record, then set the parameter MSB
               rec_new           = '0;
               rec_new.param_msb = s1_b2_ff;
               rec_wr            = 1'b1;
            end
            mcnd_pkg::CC_PARAM_LSB: begin
               rec_new.param_lsb = s1_b2_ff;
               rec_wr            = 1'b1;
            end
            mcnd_pkg::CC_DATA_MSB: begin
               rec_new.data_msb = s1_b2_ff;
               rec_wr           = 1'b1;
            end
            mcnd_pkg::CC_DATA_LSB: begin
               rec_new.data_lsb = s1_b2_ff;
               rec_wr           = 1'b1;
               nr_valid         = 1'b1;
               nr_param         = {rec_base.param_msb, rec_base.param_lsb};
               nr_value         = {rec_base.data_msb, s1_b2_ff};
            end
            default: begin
               rec_wr = 1'b0;
            end
         endcase
      end
   end

   // Control state of stage 1 and the valid bits of the store
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_fwd_ff    <= 1'b0;
         entry_vld_ff <= '0;
      end else begin
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
            s1_fwd_ff   <= s1_fwd_in;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv && rec_wr) begin
            entry_vld_ff[s1_addr_ff] <= 1'b1;
         end
      end
   end

   // Stage 1 payload; hold while stalled
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cc_ff       <= req_port.is_control_change;
         s1_in_store_ff <= req_in_store;
         s1_chan_ff     <= req_port.chan;
         s1_addr_ff     <= req_addr;
         s1_b1_ff       <= pr_b1;
         s1_b2_ff       <= pr_b2;
         s1_pvalid_ff   <= pr_valid;
         s1_plsb_ff     <= pr_lsb;
         s1_fwd_rec_ff  <= rec_new;
         s1_present_ff  <= entry_vld_ff[req_addr];
      end
   end

   // ---------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------
   logic [mcnd_pkg::CHAN_W-1:0] rsp_chan_ff;
   logic [mcnd_pkg::BYTE_W-1:0] rsp_b1_ff;
   logic [mcnd_pkg::BYTE_W-1:0] rsp_b2_ff;
   logic                        rsp_pvalid_ff;
   logic [mcnd_pkg::BYTE_W-1:0] rsp_plsb_ff;
   logic                        rsp_nvalid_ff;
   logic [mcnd_pkg::WORD_W-1:0] rsp_param_ff;
   logic [mcnd_pkg::WORD_W-1:0] rsp_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_chan_ff   <= s1_chan_ff;
         rsp_b1_ff     <= s1_b1_ff;
         rsp_b2_ff     <= s1_b2_ff;
         rsp_pvalid_ff <= s1_pvalid_ff;
         rsp_plsb_ff   <= s1_plsb_ff;
         rsp_nvalid_ff <= nr_valid;
         rsp_param_ff  <= nr_param;
         rsp_value_ff  <= nr_value;
      end
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.out_chan     = rsp_chan_ff;
   assign rsp_port.out_byte_one = rsp_b1_ff;
   assign rsp_port.out_byte_two = rsp_b2_ff;
   assign rsp_port.pair_valid   = rsp_pvalid_ff;
   assign rsp_port.pair_lsb     = rsp_plsb_ff;
   assign rsp_port.nrpn_valid   = rsp_nvalid_ff;
   assign rsp_port.nrpn_param   = rsp_param_ff;
   assign rsp_port.nrpn_value   = rsp_value_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `ASSERT_NEXT(a_adv_loads_rsp, clock, reset, s1_adv, rsp_valid_ff)
   `ASSERT_ALWAYS(a_nrpn_on_data_lsb, clock, reset,
      !(rsp_valid_ff && rsp_nvalid_ff) || rsp_b1_ff == mcnd_pkg::CC_DATA_LSB)
   `ASSERT_ALWAYS(a_nrpn_zero_idle, clock, reset,
      !(rsp_valid_ff && !rsp_nvalid_ff) || (rsp_param_ff == '0 && rsp_value_ff == '0))
   `ASSERT_ALWAYS(a_pair_msb_ctl, clock, reset,
      !(rsp_valid_ff && rsp_pvalid_ff) || rsp_b1_ff < mcnd_pkg::LSB_OFFSET)

endmodule

>>> rtl/mcnd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mcnd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sim/tb_midi_cc14_nrpn_decoder_unit.sv
// Testbench for midi_cc14_nrpn_decoder_unit: drives decoded MIDI requests and slot
// writes, predicts every response in-line and checks it. Depends on mcnd_pkg,
// mcnd_if and the unit's RTL.
module tb_midi_cc14_nrpn_decoder_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TAIL_CYCLES   = 8;
   localparam int PHASE_ITEMS   = 180;
   localparam int STALL_CYCLES  = 100;
   localparam int REPORT_LIMIT  = 10;

   typedef enum logic [mcnd_pkg::CSR_IDX_W-1:0] {
      PAIR_SLOT0_REG,
      PAIR_SLOT1_REG,
      PAIR_SLOT2_REG,
      PAIR_SLOT3_REG
   } slot_reg_type;

   typedef struct packed {
      logic                        is_cc;
      logic [mcnd_pkg::CHAN_W-1:0] chan;
      logic [mcnd_pkg::BYTE_W-1:0] byte_one;
      logic [mcnd_pkg::BYTE_W-1:0] byte_two;
   } midi_msg_type;

   typedef struct packed {
      logic [mcnd_pkg::CHAN_W-1:0] chan;
      logic [mcnd_pkg::BYTE_W-1:0] byte_one;
      logic [mcnd_pkg::BYTE_W-1:0] byte_two;
      logic                        pair_valid;
      logic [mcnd_pkg::BYTE_W-1:0] pair_lsb;
      logic                        nrpn_valid;
      logic [mcnd_pkg::WORD_W-1:0] nrpn_param;
      logic [mcnd_pkg::WORD_W-1:0] nrpn_value;
   } decoded_msg_type;

   logic clock;
   logic reset;

   mcnd_req_if req_bus ();
   mcnd_rsp_if rsp_bus ();
   mcnd_csr_if csr_bus ();

   midi_cc14_nrpn_decoder_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   // Shadow of the block: slot registers, stored MSB per slot, NRPN record per channel.
   mcnd_pkg::pair_slot_type     slot_cfg [mcnd_pkg::PAIR_SLOTS];
   logic [mcnd_pkg::BYTE_W-1:0] slot_msb [mcnd_pkg::PAIR_SLOTS];
   mcnd_pkg::nrpn_rec_type      chan_rec [mcnd_pkg::CHANNELS];

   // Decoded responses still owed by the block, oldest first.
   decoded_msg_type pending_decodes [$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned rsp_hold_left = 0;
   int unsigned requests_sent = 0;
   int unsigned mismatch_count = 0;

   always #2 clock = ~clock;

   // Compute the response to one request and advance the shadow state.
   function automatic decoded_msg_type decode_midi(input midi_msg_type m);
      decoded_msg_type             r;
      logic [mcnd_pkg::BYTE_W-1:0] ctl;
      logic [mcnd_pkg::BYTE_W-1:0] val;
      logic [mcnd_pkg::BYTE_W-1:0] slot_ctl;
      bit                          done;
      r    = '0;
      ctl  = m.byte_one;
      val  = m.byte_two;
      done = 1'b0;
      if (m.is_cc) begin
         // Pairing: first enabled slot on this channel whose MSB or LSB controller matches.
         for (int i = 0; i < mcnd_pkg::PAIR_SLOTS; i++) begin
            slot_ctl = mcnd_pkg::BYTE_W'(slot_cfg[i].ctl);
            if (!done && slot_cfg[i].enable && slot_cfg[i].chan == m.chan) begin
               if (m.byte_one == slot_ctl) begin
                  slot_msb[i] = m.byte_two;
                  done        = 1'b1;
               end else if (m.byte_one == slot_ctl + mcnd_pkg::LSB_OFFSET) begin
                  r.pair_valid = 1'b1;
                  r.pair_lsb   = m.byte_two;
                  ctl          = slot_ctl;
                  val          = slot_msb[i];
                  done         = 1'b1;
               end
            end
         end
         // NRPN assembly sees the possibly rewritten controller and value.
         if (int'(m.chan) < mcnd_pkg::CHANNELS) begin
            if (ctl == mcnd_pkg::CC_PARAM_MSB) begin
               chan_rec[m.chan]           = '0;
               chan_rec[m.chan].param_msb = val;
            end else if (ctl == mcnd_pkg::CC_PARAM_LSB) begin
               chan_rec[m.chan].param_lsb = val;
            end else if (ctl == mcnd_pkg::CC_DATA_MSB) begin
               chan_rec[m.chan].data_msb = val;
            end else if (ctl == mcnd_pkg::CC_DATA_LSB) begin
               chan_rec[m.chan].data_lsb = val;
               r.nrpn_valid = 1'b1;
               r.nrpn_param = {chan_rec[m.chan].param_msb, chan_rec[m.chan].param_lsb};
               r.nrpn_value = {chan_rec[m.chan].data_msb, chan_rec[m.chan].data_lsb};
            end
         end
      end
      r.chan     = m.chan;
      r.byte_one = ctl;
      r.byte_two = val;
      return r;
   endfunction

   function automatic string show_decode(input decoded_msg_type d);
      return $sformatf("chan=%0d b1=%0d b2=%0d pair=%0b/%0d nrpn=%0b/%0d/%0d",
                       d.chan, d.byte_one, d.byte_two, d.pair_valid, d.pair_lsb,
                       d.nrpn_valid, d.nrpn_param, d.nrpn_value);
   endfunction

   // Compare one accepted response with the oldest prediction.
   task automatic check_decode();
      decoded_msg_type got;
      decoded_msg_type want;
      got = '{rsp_bus.out_chan, rsp_bus.out_byte_one, rsp_bus.out_byte_two,
              rsp_bus.pair_valid, rsp_bus.pair_lsb, rsp_bus.nrpn_valid,
              rsp_bus.nrpn_param, rsp_bus.nrpn_value};
      if (pending_decodes.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: response with none outstanding: %s", $realtime, show_decode(got));
         return;
      end
      want = pending_decodes.pop_front();
      if (got.chan !== want.chan || got.byte_one !== want.byte_one ||
          got.byte_two !== want.byte_two || got.pair_valid !== want.pair_valid ||
          got.pair_lsb !== want.pair_lsb || got.nrpn_valid !== want.nrpn_valid ||
          got.nrpn_param !== want.nrpn_param || got.nrpn_value !== want.nrpn_value) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: response mismatch", $realtime);
            $display("   expected %s", show_decode(want));
            $display("   actual   %s", show_decode(got));
         end
      end
   endtask

   // Response side: check on every handshake, then pick next cycle's ready.
   // A long hold-off is counted down here; it is armed from the pressure test.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         check_decode();
      if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one request; predict its response once it is accepted.
   // Valid stays high after acceptance so back-to-back requests need no toggle.
   task automatic send_msg(input logic cc, input logic [mcnd_pkg::CHAN_W-1:0] ch,
                           input logic [mcnd_pkg::BYTE_W-1:0] b1,
                           input logic [mcnd_pkg::BYTE_W-1:0] b2);
      midi_msg_type m;
      m = '{cc, ch, b1, b2};
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid             <= 1'b1;
      req_bus.is_control_change <= cc;
      req_bus.chan              <= ch;
      req_bus.byte_one          <= b1;
      req_bus.byte_two          <= b2;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      pending_decodes = {pending_decodes, decode_midi(m)};
      requests_sent++;
   endtask

   // Drop valid and wait until every predicted response has come back.
   task automatic drain_decodes();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_decodes.size() != 0);
   endtask

   // Write one slot register; valid is left high for a following write.
   task automatic write_reg(input slot_reg_type idx, input mcnd_pkg::pair_slot_type value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      slot_cfg[idx] = value;
   endtask

   // Rewrite all four slots; call only with nothing in flight.
   task automatic set_slots(input mcnd_pkg::pair_slot_type s0,
                            input mcnd_pkg::pair_slot_type s1,
                            input mcnd_pkg::pair_slot_type s2,
                            input mcnd_pkg::pair_slot_type s3);
      write_reg(PAIR_SLOT0_REG, s0);
      write_reg(PAIR_SLOT1_REG, s1);
      write_reg(PAIR_SLOT2_REG, s2);
      write_reg(PAIR_SLOT3_REG, s3);
      csr_bus.valid <= 1'b0;
   endtask

   // Favor a few channels so slots and NRPN records collide often.
   function automatic logic [mcnd_pkg::CHAN_W-1:0] pick_chan();
      if ($urandom_range(9) < 7)
         return mcnd_pkg::CHAN_W'($urandom_range(3));
      return mcnd_pkg::CHAN_W'($urandom_range(15));
   endfunction

   function automatic mcnd_pkg::pair_slot_type random_slot();
      mcnd_pkg::pair_slot_type s;
      s.enable = ($urandom_range(3) != 0);
      s.chan   = pick_chan();
      case ($urandom_range(3))
         0:       s.ctl = mcnd_pkg::CTL_W'(mcnd_pkg::CC_DATA_MSB); // data LSB becomes data MSB
         1:       s.ctl = mcnd_pkg::CTL_W'($urandom_range(3));
         default: s.ctl = mcnd_pkg::CTL_W'($urandom_range(31));
      endcase
      return s;
   endfunction

   task automatic send_noise();
      logic [mcnd_pkg::BYTE_W-1:0] code;
      if ($urandom_range(3) == 0) begin
         case ($urandom_range(3))
            0:       code = mcnd_pkg::CC_PARAM_MSB;
            1:       code = mcnd_pkg::CC_PARAM_LSB;
            2:       code = mcnd_pkg::CC_DATA_MSB;
            default: code = mcnd_pkg::CC_DATA_LSB;
         endcase
         send_msg(1'($urandom_range(1)), pick_chan(), code,
                  mcnd_pkg::BYTE_W'($urandom_range(127)));
      end else begin
         send_msg(1'($urandom_range(1)), mcnd_pkg::CHAN_W'($urandom_range(15)),
                  mcnd_pkg::BYTE_W'($urandom_range(127)),
                  mcnd_pkg::BYTE_W'($urandom_range(127)));
      end
   endtask

   // One random unit: an NRPN sequence, a paired controller, or noise.
   task automatic send_random_unit();
      int unsigned                 kind;
      int unsigned                 slot;
      logic [mcnd_pkg::CHAN_W-1:0] ch;
      logic [mcnd_pkg::BYTE_W-1:0] ctl;
      kind = $urandom_range(99);
      ch   = pick_chan();
      if (kind < 45) begin
         // Well-formed NRPN with random content; drop a step or interleave noise now and then.
         if ($urandom_range(9) != 0)
            send_msg(1'b1, ch, mcnd_pkg::CC_PARAM_MSB, mcnd_pkg::BYTE_W'($urandom_range(127)));
         if ($urandom_range(9) != 0)
            send_msg(1'b1, ch, mcnd_pkg::CC_PARAM_LSB, mcnd_pkg::BYTE_W'($urandom_range(127)));
         if ($urandom_range(7) == 0)
            send_noise();
         if ($urandom_range(9) != 0)
            send_msg(1'b1, ch, mcnd_pkg::CC_DATA_MSB, mcnd_pkg::BYTE_W'($urandom_range(127)));
         send_msg(1'b1, ch, mcnd_pkg::CC_DATA_LSB, mcnd_pkg::BYTE_W'($urandom_range(127)));
         if ($urandom_range(3) == 0)
            send_msg(1'b1, ch, mcnd_pkg::CC_DATA_LSB, mcnd_pkg::BYTE_W'($urandom_range(127)));
      end else if (kind < 75) begin
         // MSB (mostly) then LSB on a configured slot, enabled or not.
         slot = $urandom_range(mcnd_pkg::PAIR_SLOTS - 1);
         ch   = slot_cfg[slot].chan;
         ctl  = mcnd_pkg::BYTE_W'(slot_cfg[slot].ctl);
         if ($urandom_range(4) != 0)
            send_msg(1'b1, ch, ctl, mcnd_pkg::BYTE_W'($urandom_range(127)));
         send_msg(1'b1, ch, ctl + mcnd_pkg::LSB_OFFSET, mcnd_pkg::BYTE_W'($urandom_range(127)));
      end else begin
         send_noise();
      end
   endtask

   // Slots disabled: messages pass through, NRPN records fill at field extremes.
   task automatic test_passthrough_after_reset();
      set_slots('{1'b0, 4'd15, 5'd31}, '0, '0, '0);
      send_msg(1'b0, 4'd15, 7'd127, 7'd127);
      send_msg(1'b0, 4'd0, 7'd0, 7'd0);
      send_msg(1'b1, 4'd0, mcnd_pkg::CC_DATA_LSB, 7'd0);    // data LSB on a cleared record
      send_msg(1'b1, 4'd15, mcnd_pkg::CC_PARAM_MSB, 7'd127);
      send_msg(1'b1, 4'd15, mcnd_pkg::CC_PARAM_LSB, 7'd127);
      send_msg(1'b1, 4'd15, mcnd_pkg::CC_DATA_MSB, 7'd127);
      send_msg(1'b1, 4'd15, mcnd_pkg::CC_DATA_LSB, 7'd127); // both words at their maximum
      send_msg(1'b1, 4'd15, mcnd_pkg::CC_PARAM_MSB, 7'd1);  // clears the rest of the record
      send_msg(1'b1, 4'd15, mcnd_pkg::CC_DATA_LSB, 7'd2);
      send_msg(1'b1, 4'd15, 7'd31, 7'd5);                   // disabled slot never matches
      send_msg(1'b1, 4'd15, 7'd63, 7'd9);
      send_msg(1'b0, 4'd15, mcnd_pkg::CC_DATA_LSB, 7'd3);   // not a control change
      send_msg(1'b1, 4'd3, 7'd127, 7'd64);                  // unrelated controller
      drain_decodes();
   endtask

   // Pairing: store MSB, merge on LSB, rewrite into data MSB, first slot wins.
   task automatic test_pair_rewrite();
      set_slots('{1'b1, 4'd0, mcnd_pkg::CTL_W'(mcnd_pkg::CC_DATA_MSB)}, '{1'b1, 4'd15, 5'd31},
                '{1'b0, 4'd0, 5'd7}, '{1'b1, 4'd0, mcnd_pkg::CTL_W'(mcnd_pkg::CC_DATA_MSB)});
      send_msg(1'b1, 4'd0, mcnd_pkg::CC_DATA_MSB, 7'd100);
      send_msg(1'b1, 4'd0, mcnd_pkg::CC_DATA_LSB, 7'd5);    // merged, seen as data MSB
      send_msg(1'b1, 4'd15, 7'd31, 7'd127);
      send_msg(1'b1, 4'd15, 7'd63, 7'd0);
      send_msg(1'b1, 4'd0, 7'd7, 7'd1);
      send_msg(1'b1, 4'd0, 7'd39, 7'd2);
      send_msg(1'b1, 4'd14, 7'd63, 7'd3);                   // channel does not match
      send_msg(1'b0, 4'd0, mcnd_pkg::CC_DATA_LSB, 7'd4);
      drain_decodes();
   endtask

   // Random traffic under one idling mode, with a random and an extreme slot setting.
   task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                      input bit slots_all_ones);
      int unsigned             stop_at;
      mcnd_pkg::pair_slot_type edge_slot;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      edge_slot = slots_all_ones ? '1 : '0;
      for (int phase = 0; phase < 2; phase++) begin
         if (phase == 0)
            set_slots(random_slot(), random_slot(), random_slot(), random_slot());
         else
            set_slots(edge_slot, edge_slot, edge_slot, edge_slot);
         stop_at = requests_sent + PHASE_ITEMS;
         while (requests_sent < stop_at) send_random_unit();
         drain_decodes();
      end
   endtask

   // Hold the response side off for a long stretch while requests keep coming,
   // so the unit fills and stalls its request side.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_slots(random_slot(), random_slot(), random_slot(), random_slot());
      rsp_hold_left <= STALL_CYCLES;
      for (int n = 0; n < 12; n++) send_random_unit();
      drain_decodes();
   endtask

   initial begin
      clock                     = 1'b0;
      reset                     = 1'b1;
      req_bus.valid             = 1'b0;
      req_bus.is_control_change = 1'b0;
      req_bus.chan              = '0;
      req_bus.byte_one          = '0;
      req_bus.byte_two          = '0;
      rsp_bus.ready             = 1'b0;
      csr_bus.valid             = 1'b0;
      csr_bus.index             = PAIR_SLOT0_REG;
      csr_bus.data              = '0;
      foreach (slot_cfg[i]) begin
         slot_cfg[i] = '0;
         slot_msb[i] = '0;
      end
      foreach (chan_rec[i]) chan_rec[i] = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_passthrough_after_reset();
      test_pair_rewrite();
      test_random_traffic(18, 53, 1'b1);
      test_random_traffic(53, 18, 1'b0);
      test_random_traffic(0, 0, 1'b1);
      test_backpressure();

      // Let any stray response show up before the verdict.
      drain_decodes();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/mcnd_pkg.sv
rtl/mcnd_if.sv
rtl/mcnd_ram.sv
rtl/midi_cc14_nrpn_decoder_unit.sv
sim/tb_midi_cc14_nrpn_decoder_unit.sv
